FILE: sv/lcc_pkg.sv
`timescale 1ns / 1ps
// lcc_pkg: shared constants, types and helpers for the luhn card number checker
package lcc_pkg;

  localparam int NUM_BITS   = 54;
  localparam int NUM_DIGITS = 17;
  localparam int MAX_DIGITS = 16;
  localparam int BIT_CNT_W  = $clog2(NUM_BITS);
  localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);
  localparam int TOTAL_W    = 8;
  localparam int PAIR_W     = 7;

  localparam logic [DCNT_W-1:0] LEN_AMEX   = DCNT_W'(15);
  localparam logic [DCNT_W-1:0] LEN_LONG   = DCNT_W'(16);
  localparam logic [DCNT_W-1:0] LEN_SHORT  = DCNT_W'(13);
  localparam logic [PAIR_W-1:0] PAIR_AMEX_A = PAIR_W'(34);
  localparam logic [PAIR_W-1:0] PAIR_AMEX_B = PAIR_W'(37);
  localparam logic [PAIR_W-1:0] PAIR_MC_LO  = PAIR_W'(51);
  localparam logic [PAIR_W-1:0] PAIR_MC_HI  = PAIR_W'(55);
  localparam logic [3:0]        LEAD_VISA   = 4'd4;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_AMEX    = 2'd1,
    KIND_MASTER  = 2'd2,
    KIND_VISA    = 2'd3
  } kind_t;

  typedef struct packed {
    logic clear;
    logic conv;
    logic unload;
  } cell_ctl_t;

  typedef struct packed {
    logic              clear;
    logic              step;
    logic [DCNT_W-1:0] pos;
  } tally_ctl_t;

  // true when the total is a multiple of ten
  function automatic logic is_mult10(input logic [TOTAL_W-1:0] total);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k * 10 < (1 << TOTAL_W); k++) begin
      if (total == TOTAL_W'(k * 10)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

FILE: sv/luhn_card_number_checker_core.sv
`timescale 1ns / 1ps
// luhn_card_number_checker_core: top level, sequencer and bcd digit cell chain
//
//  channel | signals                          | dir | word
//  card    | card_valid card_ready            | in  | card_number[53:0]
//  result  | result_valid result_ready        | out | card_kind digit_count
//          |                                  |     | leading_pair checksum_total luhn_ok
//
// one word passes through 1 accept, 54 shift-and-add-3 steps through the
// 17 digit cells (one input bit a cycle), 17 steps unloading the digits into the tally,
// and 1 step presenting the result
// the result is held until result_ready; card_ready is high only when idle
// synchronous active-high reset returns the sequencer to idle with no result pending
module luhn_card_number_checker_core #(
  parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          card_valid,
  output logic                          card_ready,
  input  logic [lcc_pkg::NUM_BITS-1:0]  card_number,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    card_kind,
  output logic [4:0]                    digit_count,
  output logic [6:0]                    leading_pair,
  output logic [7:0]                    checksum_total,
  output logic                          luhn_ok
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [lcc_pkg::BIT_CNT_W-1:0]   cnt;
  logic [lcc_pkg::BIT_CNT_W-1:0]   cnt_next;
  logic [lcc_pkg::NUM_BITS-1:0]    shreg;
  lcc_pkg::cell_ctl_t              cell_ctl;
  lcc_pkg::tally_ctl_t             tally_ctl;
  logic                            accept;

  logic [lcc_pkg::NUM_DIGITS:0]    carry;
  logic [3:0]                      digits [0:lcc_pkg::NUM_DIGITS];

  assign accept       = card_valid && card_ready;
  assign card_ready   = (state == ST_IDLE);
  assign result_valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (card_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (cnt == lcc_pkg::BIT_CNT_W'(lcc_pkg::NUM_BITS - 1)) begin
          state_next = ST_SCAN;
          cnt_next   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt == lcc_pkg::BIT_CNT_W'(lcc_pkg::NUM_DIGITS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cnt_next = '0;
        if (result_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= card_number;
    end else if (state == ST_CONV) begin
      shreg <= {shreg[lcc_pkg::NUM_BITS-2:0], 1'b0};
    end
  end

  assign cell_ctl.clear  = accept;
  assign cell_ctl.conv   = (state == ST_CONV);
  assign cell_ctl.unload = (state == ST_SCAN);

  assign tally_ctl.clear = accept;
  assign tally_ctl.step  = (state == ST_SCAN);
  assign tally_ctl.pos   = lcc_pkg::DCNT_W'(cnt) + 1'b1;

  assign carry[0]                      = shreg[lcc_pkg::NUM_BITS-1];
  assign digits[lcc_pkg::NUM_DIGITS]   = 4'd0;

  for (genvar i = 0; i < lcc_pkg::NUM_DIGITS; i++) begin : g_cell
    lcc_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .carry_in  (carry[i]),
      .upper     (digits[i+1]),
      .carry_out (carry[i+1]),
      .digit     (digits[i])
    );
  end

  lcc_tally #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_tally (
    .clk            (clk),
    .ctl            (tally_ctl),
    .digit          (digits[0]),
    .card_kind      (card_kind),
    .digit_count    (digit_count),
    .leading_pair   (leading_pair),
    .checksum_total (checksum_total),
    .luhn_ok        (luhn_ok)
  );

endmodule

FILE: sv/lcc_cell.sv
`timescale 1ns / 1ps
// lcc_cell: one bcd digit cell of the shift-and-add-3 conversion chain
module lcc_cell (
  input  logic                 clk,
  input  lcc_pkg::cell_ctl_t   ctl,
  input  logic                 carry_in,
  input  logic [3:0]           upper,
  output logic                 carry_out,
  output logic [3:0]           digit
);

  logic [3:0] adj;

  assign adj       = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= 4'd0;
    end else if (ctl.conv) begin
      digit <= {adj[2:0], carry_in};
    end else if (ctl.unload) begin
      digit <= upper;
    end
  end

endmodule

FILE: sv/lcc_tally.sv
`timescale 1ns / 1ps
// lcc_tally: luhn sum, digit count, leading digits and card kind over the digit stream
module lcc_tally #(
  parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS
) (
  input  logic                                 clk,
  input  lcc_pkg::tally_ctl_t                  ctl,
  input  logic [3:0]                           digit,
  output logic [1:0]                           card_kind,
  output logic [4:0]                           digit_count,
  output logic [lcc_pkg::PAIR_W-1:0]           leading_pair,
  output logic [lcc_pkg::TOTAL_W-1:0]          checksum_total,
  output logic                                 luhn_ok
);

  logic [lcc_pkg::DCNT_W-1:0]  count;
  logic [lcc_pkg::TOTAL_W-1:0] total;
  logic [3:0]                  first;
  logic [3:0]                  second;
  logic [3:0]                  prev;
  logic [4:0]                  dbl;
  logic [4:0]                  folded;
  logic [4:0]                  addend;
  logic [lcc_pkg::PAIR_W-1:0]  pair;
  lcc_pkg::kind_t              kind;

  assign dbl    = {digit, 1'b0};
  assign folded = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
  assign addend = ctl.pos[0] ? {1'b0, digit} : folded;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      count  <= '0;
      total  <= '0;
      first  <= 4'd0;
      second <= 4'd0;
      prev   <= 4'd0;
    end else if (ctl.step) begin
      total <= total + lcc_pkg::TOTAL_W'(addend);
      prev  <= digit;
      if (digit != 4'd0) begin
        count  <= ctl.pos;
        first  <= digit;
        second <= prev;
      end
    end
  end

  assign pair = (lcc_pkg::PAIR_W'(first) << 3) + (lcc_pkg::PAIR_W'(first) << 1)
              + lcc_pkg::PAIR_W'(second);

  always_comb begin
    kind = lcc_pkg::KIND_INVALID;
    if (count <= lcc_pkg::DCNT_W'(MAX_DIGITS)) begin
      if (count == lcc_pkg::LEN_AMEX &&
          (pair == lcc_pkg::PAIR_AMEX_A || pair == lcc_pkg::PAIR_AMEX_B)) begin
        kind = lcc_pkg::KIND_AMEX;
      end else if (count == lcc_pkg::LEN_LONG &&
                   pair inside {[lcc_pkg::PAIR_MC_LO:lcc_pkg::PAIR_MC_HI]}) begin
        kind = lcc_pkg::KIND_MASTER;
      end else if ((count == lcc_pkg::LEN_SHORT || count == lcc_pkg::LEN_LONG) &&
                   first == lcc_pkg::LEAD_VISA) begin
        kind = lcc_pkg::KIND_VISA;
      end
    end
  end

  assign card_kind      = kind;
  assign digit_count    = 5'(count);
  assign leading_pair   = pair;
  assign checksum_total = total;
  assign luhn_ok        = lcc_pkg::is_mult10(total);

endmodule
